// File: rtl/pfd_pkg.sv
package pfd_pkg;

    localparam logic [6:0] THR_RESET = 7'd60;
    localparam logic [6:0] DUTY_CEIL = 7'd101;
    localparam logic [6:0] PID_MAG_MAX = 7'd127;

    localparam logic signed [31:0] SUM_LIMIT = 32'sh7FFF_FFFF;

    localparam logic signed [16:0] HYST_C = 17'sd500;
    localparam logic signed [16:0] RAMP_T_LO = 17'sd5500;
    localparam logic signed [16:0] RAMP_T_HI = 17'sd8000;
    localparam logic [17:0] RAMP_OFFSET = 18'd75000;
    localparam logic [6:0] RAMP_SLOPE = 7'd71;
    localparam logic [13:0] CENTI_PER_DEG = 14'd100;

    // floor(2^26 / 625) + 1 and floor(2^40 / 625).
    localparam logic [16:0] RAMP_RECIP = 17'd107375;
    localparam logic [30:0] DIV_RECIP = 31'd1759218604;
    localparam logic [29:0] DIV_STEP = 30'd625;

    typedef enum logic [1:0] {
        BASE_OFF,
        BASE_RAMP,
        BASE_FULL,
        BASE_HOLD
    } base_sel_t;

    typedef struct packed {
        logic signed [15:0] err;
        logic signed [31:0] sum;
        logic signed [16:0] diff;
        base_sel_t          sel;
        logic [15:0]        ramp_num;
    } err_item_t;

    typedef struct packed {
        logic signed [7:0] pid;
        base_sel_t         sel;
        logic [6:0]        ramp_duty;
    } pid_item_t;

endpackage

// File: rtl/pfd_temp_if.sv
interface pfd_temp_if;
    logic               valid;
    logic               ready;
    logic signed [14:0] temp_centideg;

    modport source (output valid, output temp_centideg, input ready);
    modport sink (input valid, input temp_centideg, output ready);
endinterface

// File: rtl/pfd_duty_if.sv
interface pfd_duty_if;
    logic       valid;
    logic       ready;
    logic [6:0] fan_duty;

    modport source (output valid, output fan_duty, input ready);
    modport sink (input valid, input fan_duty, output ready);
endinterface

// File: rtl/pfd_err_stage.sv
module pfd_err_stage
    import pfd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [6:0]         thr,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [14:0] temp,
    output logic               out_valid,
    input  logic               out_ready,
    output err_item_t          out_item
);

    logic                 valid_reg;
    err_item_t            item_reg;
    logic signed [31:0]   error_sum_reg;
    logic signed [31:0]   error_sum_next;
    logic signed [15:0]   prev_error_reg;
    logic                 accept;
    logic signed [16:0]   temp_ext;
    logic [13:0]          thr_prod;
    logic signed [16:0]   thr_c;
    logic signed [16:0]   err_wide;
    logic signed [15:0]   err;
    logic signed [32:0]   sum_wide;
    logic signed [16:0]   diff;
    logic signed [16:0]   ramp_off;
    logic [17:0]          ramp_full;
    base_sel_t            sel;

    assign in_ready  = !valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb
    begin
        temp_ext = 17'(temp);
        thr_prod = thr * CENTI_PER_DEG;
        thr_c    = $signed({3'b000, thr_prod});
        err_wide = temp_ext - thr_c;
        err      = err_wide[15:0];
        sum_wide = 33'(error_sum_reg) + 33'(err);
        if (sum_wide > 33'(SUM_LIMIT))
        begin
            error_sum_next = SUM_LIMIT;
        end
        else if (sum_wide < -33'(SUM_LIMIT))
        begin
            error_sum_next = -SUM_LIMIT;
        end
        else
        begin
            error_sum_next = sum_wide[31:0];
        end
        diff = 17'(err) - 17'(prev_error_reg);

        if (temp_ext <= thr_c + HYST_C)
        begin
            sel = BASE_OFF;
        end
        else if (temp_ext >= RAMP_T_LO && temp_ext <= RAMP_T_HI)
        begin
            sel = BASE_RAMP;
        end
        else if (temp_ext > RAMP_T_HI)
        begin
            sel = BASE_FULL;
        end
        else
        begin
            sel = BASE_HOLD;
        end

        // The ramp numerator is 71 * (T - 5500) + 75000, reduced by four here.
        ramp_off  = temp_ext - RAMP_T_LO;
        ramp_full = 18'(ramp_off[11:0]) * 18'(RAMP_SLOPE) + RAMP_OFFSET;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= 1'b0;
            error_sum_reg  <= '0;
            prev_error_reg <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                valid_reg <= in_valid;
            end
            if (accept)
            begin
                error_sum_reg  <= error_sum_next;
                prev_error_reg <= err;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.err      <= err;
            item_reg.sum      <= error_sum_next;
            item_reg.diff     <= diff;
            item_reg.sel      <= sel;
            item_reg.ramp_num <= ramp_full[17:2];
        end
    end

    a_sum_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        error_sum_reg != 32'sh8000_0000)
        else $error("error sum left its saturation range");

    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(error_sum_reg) && $stable(prev_error_reg))
        else $error("controller state changed without a new item");

endmodule

// File: rtl/pfd_pid_div.sv
module pfd_pid_div
    import pfd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  err_item_t in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output pid_item_t out_item
);

    logic               b_valid_reg;
    logic [29:0]        b_mag_reg;
    logic               b_neg_reg;
    base_sel_t          b_sel_reg;
    logic [6:0]         b_ramp_reg;
    logic               c_valid_reg;
    logic [20:0]        c_q0_reg;
    logic [29:0]        c_mag_reg;
    logic               c_neg_reg;
    base_sel_t          c_sel_reg;
    logic [6:0]         c_ramp_reg;
    logic               d_valid_reg;
    pid_item_t          d_item_reg;

    logic               b_ready;
    logic               c_ready;
    logic               d_ready;
    logic signed [35:0] num;
    logic [35:0]        num_mag;
    logic [32:0]        ramp_prod;
    logic [60:0]        div_prod;
    logic [29:0]        q0_back;
    logic [29:0]        rem;
    logic [20:0]        quot;
    logic [6:0]         pid_mag;
    logic signed [7:0]  pid;

    assign d_ready   = !d_valid_reg || out_ready;
    assign c_ready   = !c_valid_reg || d_ready;
    assign b_ready   = !b_valid_reg || c_ready;
    assign in_ready  = b_ready;
    assign out_valid = d_valid_reg;
    assign out_item  = d_item_reg;

    always_comb
    begin
        num = 36'(in_item.err) * 36'sd100 + 36'(in_item.sum) * 36'sd3
            + 36'(in_item.diff) * 36'sd10;
        num_mag   = num[35] ? -num : num;
        ramp_prod = 33'(in_item.ramp_num) * 33'(RAMP_RECIP);

        div_prod = 61'(b_mag_reg) * 61'(DIV_RECIP);

        // The reciprocal estimate is at most one short of the true quotient.
        q0_back = 30'(c_q0_reg) * DIV_STEP;
        rem     = c_mag_reg - q0_back;
        quot    = c_q0_reg + 21'(rem >= DIV_STEP);
        pid_mag = (quot > 21'(PID_MAG_MAX)) ? PID_MAG_MAX : quot[6:0];
        pid     = c_neg_reg ? -$signed({1'b0, pid_mag}) : $signed({1'b0, pid_mag});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            if (b_ready)
            begin
                b_valid_reg <= in_valid;
            end
            if (c_ready)
            begin
                c_valid_reg <= b_valid_reg;
            end
            if (d_ready)
            begin
                d_valid_reg <= c_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && in_valid)
        begin
            b_mag_reg  <= num_mag[33:4];
            b_neg_reg  <= num[35];
            b_sel_reg  <= in_item.sel;
            b_ramp_reg <= ramp_prod[32:26];
        end
        if (c_ready && b_valid_reg)
        begin
            c_q0_reg   <= div_prod[60:40];
            c_mag_reg  <= b_mag_reg;
            c_neg_reg  <= b_neg_reg;
            c_sel_reg  <= b_sel_reg;
            c_ramp_reg <= b_ramp_reg;
        end
        if (d_ready && c_valid_reg)
        begin
            d_item_reg.pid       <= pid;
            d_item_reg.sel       <= c_sel_reg;
            d_item_reg.ramp_duty <= c_ramp_reg;
        end
    end

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        c_valid_reg |-> rem < 30'd1250)
        else $error("reciprocal quotient estimate is off by more than one");

endmodule

// File: rtl/pfd_duty_out.sv
module pfd_duty_out
    import pfd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  pid_item_t in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output logic [6:0] fan_duty
);

    logic              valid_reg;
    logic [6:0]        duty_reg;
    logic [6:0]        duty_next;
    logic [6:0]        base;
    logic signed [8:0] total;
    logic              accept;

    assign in_ready  = !valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign fan_duty  = duty_reg;

    always_comb
    begin
        case (in_item.sel)
            BASE_OFF:  base = 7'd0;
            BASE_RAMP: base = in_item.ramp_duty;
            BASE_FULL: base = DUTY_CEIL;
            BASE_HOLD: base = duty_reg;
            default:   base = duty_reg;
        endcase
        total = $signed({2'b00, base}) + 9'(in_item.pid);
        if (total < 9'sd0)
        begin
            duty_next = 7'd0;
        end
        else if (total > $signed({2'b00, DUTY_CEIL}))
        begin
            duty_next = DUTY_CEIL;
        end
        else
        begin
            duty_next = total[6:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            duty_reg  <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                valid_reg <= in_valid;
            end
            if (accept)
            begin
                duty_reg <= duty_next;
            end
        end
    end

    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        duty_reg <= DUTY_CEIL)
        else $error("fan duty above its maximum");

endmodule

// File: rtl/pid_fan_duty_controller.sv
// Channel  Dir  Payload                    Handshake
// sample   in   temp_centideg, s15         valid / ready
// duty     out  fan_duty, u7               valid / ready
// cfg      in   cfg_wdata, u7 (threshold)  cfg_we, no wait
//
// The duty for an item passes the error-stage register, the divider's b, c and d registers and the duty register.
// One item is accepted every cycle while no stall on the duty side holds the pipeline.
// The error integral updates at acceptance; the previous duty feeds the last stage.
// A stall on the duty side fills the pipeline before sample ready falls.
// Reset clears the error integral, the last error and the last duty, and sets the threshold to 60.
module pid_fan_duty_controller
    import pfd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    pfd_temp_if.sink         sample,
    pfd_duty_if.source       duty,
    input  logic             cfg_we,
    input  logic [6:0]       cfg_wdata
);

    logic [6:0] thr_reg;
    logic       err_valid;
    logic       err_ready;
    err_item_t  err_item;
    logic       pid_valid;
    logic       pid_ready;
    pid_item_t  pid_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
        end
        else if (cfg_we)
        begin
            thr_reg <= cfg_wdata;
        end
    end

    pfd_err_stage u_err (
        .clk       (clk),
        .rst_n     (rst_n),
        .thr       (thr_reg),
        .in_valid  (sample.valid),
        .in_ready  (sample.ready),
        .temp      (sample.temp_centideg),
        .out_valid (err_valid),
        .out_ready (err_ready),
        .out_item  (err_item)
    );

    pfd_pid_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (err_valid),
        .in_ready  (err_ready),
        .in_item   (err_item),
        .out_valid (pid_valid),
        .out_ready (pid_ready),
        .out_item  (pid_item)
    );

    pfd_duty_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pid_valid),
        .in_ready  (pid_ready),
        .in_item   (pid_item),
        .out_valid (duty.valid),
        .out_ready (duty.ready),
        .fan_duty  (duty.fan_duty)
    );

endmodule

// File: sim/tb_pid_fan_duty_controller.sv
`timescale 1ns / 1ps

class fan_duty_scoreboard;
    logic [6:0] threshold;
    longint     integral;
    longint     last_err;
    longint     last_duty;
    logic [6:0] pending[$];
    int         errors;

    function new();
        threshold = 7'd60;
        integral  = 0;
        last_err  = 0;
        last_duty = 0;
        errors    = 0;
    endfunction

    // Computes the duty that one accepted temperature sample must produce.
    function void note_temp(logic signed [14:0] t);
        longint tc;
        longint thr_c;
        longint e;
        longint s;
        longint d;
        longint pid;
        longint base;
        longint duty;
        tc    = t;
        thr_c = longint'(threshold) * 100;
        e     = tc - thr_c;
        s     = integral + e;
        if (s > 64'sd2147483647)
        begin
            s = 64'sd2147483647;
        end
        else if (s < -64'sd2147483647)
        begin
            s = -64'sd2147483647;
        end
        integral = s;
        d        = e - last_err;
        last_err = e;
        pid      = (100 * e + 3 * s + 10 * d) / 10000;
        if (tc <= thr_c + 500)
        begin
            base = 0;
        end
        else if (tc - 500 >= 5000 && tc - 500 <= 7500)
        begin
            base = (30 * (8000 - tc) + 101 * (tc - 5500)) / 2500;
        end
        else if (tc - 500 > 7500)
        begin
            base = 101;
        end
        else
        begin
            base = last_duty;
        end
        duty = base + pid;
        if (duty > 101)
        begin
            duty = 101;
        end
        else if (duty < 0)
        begin
            duty = 0;
        end
        last_duty = duty;
        pending.push_back(duty[6:0]);
    endfunction

    task report_mismatch(string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        errors++;
    endtask

    task check_duty(logic [6:0] got);
        logic [6:0] want;
        if (pending.size() == 0)
        begin
            report_mismatch($sformatf("duty %0d with no sample outstanding", got));
        end
        else
        begin
            want = pending.pop_front();
            if (got !== want)
            begin
                report_mismatch($sformatf("fan_duty %0d, expected %0d", got, want));
            end
        end
    endtask
endclass

module tb_pid_fan_duty_controller;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic [6:0] cfg_wdata;
    int         send_idle_pct;
    int         recv_idle_pct;

    fan_duty_scoreboard fan_sb;

    pfd_temp_if temp_ch();
    pfd_duty_if duty_ch();

    pid_fan_duty_controller u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (temp_ch),
        .duty      (duty_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (duty_ch.valid && duty_ch.ready)
            begin
                fan_sb.check_duty(duty_ch.fan_duty);
            end
            duty_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
        else
        begin
            duty_ch.ready <= 1'b0;
        end
    end

    task automatic send_temp(input logic signed [14:0] t);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            temp_ch.valid <= 1'b0;
            @(posedge clk);
        end
        temp_ch.valid         <= 1'b1;
        temp_ch.temp_centideg <= t;
        do
        begin
            @(posedge clk);
        end
        while (!temp_ch.ready);
        fan_sb.note_temp(t);
    endtask

    task automatic drain_results();
        int waited;
        temp_ch.valid <= 1'b0;
        waited = 0;
        while (fan_sb.pending.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        if (fan_sb.pending.size() != 0)
        begin
            fan_sb.report_mismatch($sformatf("%0d duty results never arrived",
                                             fan_sb.pending.size()));
            fan_sb.pending.delete();
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic set_threshold(input logic [6:0] thr);
        cfg_we    <= 1'b1;
        cfg_wdata <= thr;
        @(posedge clk);
        cfg_we <= 1'b0;
        fan_sb.threshold = thr;
    endtask

    // Random samples stay near the threshold most of the time, and are pulled
    // back toward it whenever the integral drifts, so the PID term stays small.
    function automatic logic signed [14:0] pick_temp();
        longint      centre;
        longint      v;
        int unsigned roll;
        centre = longint'(fan_sb.threshold) * 100;
        roll   = $urandom_range(0, 99);
        if (fan_sb.integral > 200000)
        begin
            v = centre - longint'($urandom_range(0, 3000));
        end
        else if (fan_sb.integral < -200000)
        begin
            v = centre + longint'($urandom_range(0, 3000));
        end
        else if (roll < 60)
        begin
            v = centre + longint'($urandom_range(0, 4000)) - 2000;
        end
        else if (roll < 85)
        begin
            v = longint'($urandom_range(3000, 9000));
        end
        else
        begin
            v = longint'($urandom_range(0, 32767)) - 16384;
        end
        if (v > 16383)
        begin
            v = 16383;
        end
        else if (v < -16384)
        begin
            v = -16384;
        end
        return v[14:0];
    endfunction

    initial
    begin
        logic [6:0] thr_plan[12];
        fan_sb                = new();
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_wdata             = 7'd0;
        temp_ch.valid         = 1'b0;
        temp_ch.temp_centideg = 15'sd0;
        send_idle_pct         = 27;
        recv_idle_pct         = 72;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset threshold, both input extremes and the ramp edges.
        send_temp(-15'sd16384);
        send_temp(15'sd16383);
        send_temp(15'sd6500);
        send_temp(15'sd6501);
        send_temp(15'sd5500);
        send_temp(15'sd8000);
        send_temp(15'sd8001);
        drain_results();

        // Low threshold: samples between the turn-off point and the ramp keep the last duty.
        set_threshold(7'd30);
        send_temp(15'sd4000);
        send_temp(15'sd3500);
        send_temp(15'sd3501);
        send_temp(15'sd5499);
        send_temp(15'sd5500);
        drain_results();

        // High threshold: the turn-off test wins inside the ramp range.
        set_threshold(7'd75);
        send_temp(15'sd7000);
        send_temp(15'sd8000);
        send_temp(15'sd8001);
        drain_results();

        set_threshold(7'd127);
        send_temp(15'sd16383);
        send_temp(-15'sd16384);
        drain_results();

        set_threshold(7'd0);
        send_temp(15'sd0);
        send_temp(-15'sd1);
        send_temp(15'sd500);
        send_temp(15'sd501);
        drain_results();

        thr_plan = '{7'd0, 7'd45, 7'd100, 7'd0, 7'd127, 7'd60, 7'd0, 7'd30,
                     7'd0, 7'd50, 7'd101, 7'd0};
        thr_plan[3] = 7'($urandom_range(0, 127));
        thr_plan[6] = 7'($urandom_range(0, 127));
        thr_plan[8] = 7'($urandom_range(0, 127));

        for (int seg = 0; seg < 12; seg++)
        begin
            if (seg == 4)
            begin
                send_idle_pct = 72;
                recv_idle_pct = 27;
            end
            else if (seg == 8)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            set_threshold(thr_plan[seg]);
            for (int n = 0; n < 120; n++)
            begin
                send_temp(pick_temp());
            end
            drain_results();
        end

        if (fan_sb.errors == 0)
        begin
            $display("** pid_fan_duty_controller: PASSED **");
        end
        else
        begin
            $display("** pid_fan_duty_controller: FAILED **");
        end
        $finish;
    end

    initial
    begin
        #15_000_000;
        $display("** pid_fan_duty_controller: FAILED **");
        $finish;
    end
endmodule
